// File: src/iir_pkg.sv
// ----------------------------------------------------------------------------
// iir_pkg
// Types, constants and register codes shared by the biquad filter files.
// ----------------------------------------------------------------------------
package iir_pkg;

    localparam int IIR_SAMPLE_W = 16;
    localparam int IIR_COEF_W   = 16;
    localparam int IIR_ORDER_W  = 2;
    localparam int IIR_CFG_IDX_W = 3;
    localparam int IIR_CFG_DATA_W = 16;

    // coefficient slots provided for feedforward and feedback taps
    localparam int IIR_TAPS      = 2;
    localparam int IIR_MAX_ORDER = 2;

    // Q2.14 coefficient by Q1.15 sample gives Q3.29; five of them need 35 bits
    localparam int IIR_PROD_W  = IIR_SAMPLE_W + IIR_COEF_W;
    localparam int IIR_ACC_W   = IIR_PROD_W + 3;
    localparam int IIR_FRAC_SH = 14;
    localparam int IIR_QUOT_W  = IIR_ACC_W - IIR_FRAC_SH;

    typedef logic signed [IIR_SAMPLE_W-1:0] sample_t;
    typedef logic signed [IIR_COEF_W-1:0]   coef_t;
    typedef logic [IIR_ORDER_W-1:0]         order_t;

    typedef enum logic [IIR_CFG_IDX_W-1:0] {
        CFG_B0    = 3'd0,
        CFG_B1    = 3'd1,
        CFG_B2    = 3'd2,
        CFG_A1    = 3'd3,
        CFG_A2    = 3'd4,
        CFG_ORDER = 3'd5
    } cfg_reg_e;

    localparam coef_t   COEF_B0_RESET = 16'sd16384;
    localparam coef_t   COEF_ZERO     = 16'sd0;
    localparam order_t  ORDER_RESET   = 2'd2;
    localparam sample_t SAMPLE_MAX    = 16'sh7fff;
    localparam sample_t SAMPLE_MIN    = 16'sh8000;
    localparam logic signed [IIR_ACC_W-1:0] ROUND_HALF = 35'sd8192;

endpackage

// File: src/iir_if.sv
// ----------------------------------------------------------------------------
// iir channel interfaces
// Valid/ready channels for input samples, filtered results and register writes.
// ----------------------------------------------------------------------------
interface iir_in_if
    import iir_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    first;
    logic    last;

    modport source (output valid, output sample_in, output first, output last, input ready);
    modport sink   (input valid, input sample_in, input first, input last, output ready);
endinterface

interface iir_out_if
    import iir_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    saturated;
    logic    last_out;

    modport source (output valid, output sample_out, output saturated, output last_out,
                    input ready);
    modport sink   (input valid, input sample_out, input saturated, input last_out,
                    output ready);
endinterface

interface iir_cfg_if
    import iir_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [IIR_CFG_IDX_W-1:0]  index;
    logic [IIR_CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/iir_second_order_filter.sv
// ----------------------------------------------------------------------------
// iir_second_order_filter
// DF-I biquad, Q1.15 samples, Q2.14 coefs, one sample a clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   x_chan carries sample_in with first/last flags; y_chan returns one result
//   (sample_out, saturated, last_out) per request. cfg writes coefficient and
//   order registers by index (0 b0, 1 b1, 2 b2, 3 a1, 4 a2, 5 filter_order);
//   cfg is always ready, writes to other indexes are dropped. Write registers
//   only while no request is in flight.
//   A request sits in an input register, then the five products, their sum,
//   rounding and saturation are worked out in one pass into the result
//   register that drives y_chan.valid and the result outputs.
//   Throughput is one request per cycle unless y_chan stalls; the output
//   feeding back as y[n-1] into the next sum is the path that sets this.
//   When y_chan stalls the result register holds, an empty input register
//   takes one more request, then x_chan.ready drops until the result is taken.
//   Reset clears both stages, the history and loads the default coefficients
//   (b0 = 1.0, others 0, order 2).
// ----------------------------------------------------------------------------
module iir_second_order_filter
    import iir_pkg::*;
#(
    parameter int MAX_ORDER = IIR_MAX_ORDER
)
(
    input  logic       clk,
    input  logic       rst_n,
    iir_in_if.sink     x_chan,
    iir_out_if.source  y_chan,
    iir_cfg_if.sink    cfg
);

    // configuration
    coef_t  coef_b0_reg;
    coef_t  coef_b_reg [IIR_TAPS];
    coef_t  coef_a_reg [IIR_TAPS];
    order_t filter_order_reg;
    order_t ord_eff;

    // input stage
    logic    in_valid_reg;
    sample_t x_reg;
    logic    first_reg;
    logic    last_reg;

    // history, entry j holds the value j+1 samples back
    sample_t x_hist_reg [MAX_ORDER];
    sample_t y_hist_reg [MAX_ORDER];

    // output stage
    logic    out_valid_reg;
    sample_t y_reg;
    logic    sat_reg;
    logic    last_out_reg;

    logic    fire;
    logic    out_free;
    logic signed [IIR_ACC_W-1:0]  acc;
    logic signed [IIR_ACC_W-1:0]  rounded;
    logic signed [IIR_QUOT_W-1:0] quot;
    sample_t y_next;
    logic    sat_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg      <= COEF_B0_RESET;
            coef_b_reg       <= '{default: COEF_ZERO};
            coef_a_reg       <= '{default: COEF_ZERO};
            filter_order_reg <= ORDER_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_e'(cfg.index))
                CFG_B0:    coef_b0_reg      <= coef_t'(cfg.data);
                CFG_B1:    coef_b_reg[0]    <= coef_t'(cfg.data);
                CFG_B2:    coef_b_reg[1]    <= coef_t'(cfg.data);
                CFG_A1:    coef_a_reg[0]    <= coef_t'(cfg.data);
                CFG_A2:    coef_a_reg[1]    <= coef_t'(cfg.data);
                CFG_ORDER: filter_order_reg <= cfg.data[IIR_ORDER_W-1:0];
                default:   ;
            endcase
        end
    end

    assign ord_eff = (filter_order_reg > IIR_ORDER_W'(MAX_ORDER))
                   ? IIR_ORDER_W'(MAX_ORDER) : filter_order_reg;

    // handshake between stages
    assign out_free    = !out_valid_reg || y_chan.ready;
    assign fire        = in_valid_reg && out_free;
    assign x_chan.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (x_chan.ready)
        begin
            in_valid_reg <= x_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_chan.valid && x_chan.ready)
        begin
            x_reg     <= x_chan.sample_in;
            first_reg <= x_chan.first;
            last_reg  <= x_chan.last;
        end
    end

    // multiply-accumulate, history reads as zero at start of sequence
    always_comb
    begin
        logic signed [IIR_PROD_W-1:0] prod_b;
        logic signed [IIR_PROD_W-1:0] prod_a;
        sample_t xh;
        sample_t yh;
        prod_b = coef_b0_reg * x_reg;
        acc    = IIR_ACC_W'(prod_b);
        for (int j = 0; j < MAX_ORDER; j++)
        begin
            xh     = first_reg ? '0 : x_hist_reg[j];
            yh     = first_reg ? '0 : y_hist_reg[j];
            prod_b = coef_b_reg[j] * xh;
            prod_a = coef_a_reg[j] * yh;
            if (int'(ord_eff) > j)
            begin
                acc = acc + IIR_ACC_W'(prod_b) + IIR_ACC_W'(prod_a);
            end
        end
    end

    // round half up to Q1.15, then clip
    assign rounded = acc + ROUND_HALF;
    assign quot    = rounded[IIR_ACC_W-1:IIR_FRAC_SH];

    always_comb
    begin
        if (quot[IIR_QUOT_W-1:IIR_SAMPLE_W-1] == '0
            || quot[IIR_QUOT_W-1:IIR_SAMPLE_W-1] == '1)
        begin
            y_next   = quot[IIR_SAMPLE_W-1:0];
            sat_next = 1'b0;
        end
        else
        begin
            y_next   = quot[IIR_QUOT_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_hist_reg <= '{default: '0};
            y_hist_reg <= '{default: '0};
        end
        else if (fire)
        begin
            x_hist_reg[0] <= x_reg;
            y_hist_reg[0] <= y_next;
            for (int i = 1; i < MAX_ORDER; i++)
            begin
                x_hist_reg[i] <= first_reg ? '0 : x_hist_reg[i-1];
                y_hist_reg[i] <= first_reg ? '0 : y_hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            y_reg        <= y_next;
            sat_reg      <= sat_next;
            last_out_reg <= last_reg;
        end
    end

    assign y_chan.valid      = out_valid_reg;
    assign y_chan.sample_out = y_reg;
    assign y_chan.saturated  = sat_reg;
    assign y_chan.last_out   = last_out_reg;

    // a clipped result sits on one of the rails
    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg |-> (y_reg == SAMPLE_MAX || y_reg == SAMPLE_MIN))
        else $error("saturated result not at a rail");

    // the fed-back output equals the result just produced
    a_hist_matches: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && y_hist_reg[0] == y_reg))
        else $error("output history differs from delivered result");

    // a waiting request is neither lost nor overwritten
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(x_reg) && $stable(last_reg))
        else $error("pending request lost");

endmodule
